// ===== design/sthit_pkg.sv =====
// shared widths, types and codes for the segment / triangle hit test
package sthit_pkg;

  localparam int COORD_BITS = 32;
  localparam int CFG_IDX_W  = 3;

  // exact widths through the datapath
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int LO_W      = CROSS_W / 2;
  localparam int HI_W      = CROSS_W - LO_W;
  localparam int PART_LO_W = DIFF_W + LO_W + 1;
  localparam int PART_HI_W = DIFF_W + HI_W;
  localparam int TERM_W    = DIFF_W + CROSS_W;
  localparam int DOT_W     = TERM_W + 2;
  localparam int FOLD_W    = DOT_W + 1;
  localparam int SUM_W     = FOLD_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
  } facet_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } dvec_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] x;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] z;
  } cvec_t;

  typedef struct packed {
    dvec_t e1;
    dvec_t e2;
    dvec_t s;
    dvec_t dir;
    cvec_t h;
    cvec_t q;
  } cross_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] det;
    logic signed [DOT_W-1:0] nu;
    logic signed [DOT_W-1:0] nv;
    logic signed [DOT_W-1:0] nt;
  } dot_t;

  typedef enum logic [2:0] {
    REASON_HIT      = 3'd0,
    REASON_PARALLEL = 3'd1,
    REASON_U_OUT    = 3'd2,
    REASON_V_OUT    = 3'd3,
    REASON_T_OUT    = 3'd4
  } reason_t;

endpackage

// ===== design/sthit_facet_if.sv =====
// triangle input channel: valid, ready and three vertices
interface sthit_facet_if;
  import sthit_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vert_a_x;
  coord_t vert_a_y;
  coord_t vert_a_z;
  coord_t vert_b_x;
  coord_t vert_b_y;
  coord_t vert_b_z;
  coord_t vert_c_x;
  coord_t vert_c_y;
  coord_t vert_c_z;

  modport source (
    output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
           vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );

  modport sink (
    input  valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
           vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

// ===== design/sthit_result_if.sv =====
// result channel: valid, ready, hit flag and reason code
interface sthit_result_if;
  import sthit_pkg::*;

  logic    valid;
  logic    ready;
  logic    hit;
  reason_t reason;

  modport source (output valid, hit, reason, input ready);
  modport sink (input valid, hit, reason, output ready);
endinterface

// ===== design/sthit_cross.sv =====
// edge vectors and the two cross products h and q, three stages
module sthit_cross (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sthit_pkg::facet_t in_facet,
  input  sthit_pkg::point_t origin,
  input  sthit_pkg::point_t seg_end,
  output logic              out_valid,
  input  logic              out_ready,
  output sthit_pkg::cross_t out_data
);
  import sthit_pkg::*;

  function automatic dvec_t vdiff(point_t p, point_t r);
    dvec_t d;
    d.x = DIFF_W'(p.x) - DIFF_W'(r.x);
    d.y = DIFF_W'(p.y) - DIFF_W'(r.y);
    d.z = DIFF_W'(p.z) - DIFF_W'(r.z);
    return d;
  endfunction

  function automatic logic signed [PROD_W-1:0] mul_d(logic signed [DIFF_W-1:0] a,
                                                      logic signed [DIFF_W-1:0] b);
    return PROD_W'(a) * PROD_W'(b);
  endfunction

  // stage a: differences
  logic  a_valid;
  dvec_t a_e1, a_e2, a_s, a_dir;
  // stage b: products
  logic                     b_valid;
  logic signed [PROD_W-1:0] hp [6];
  logic signed [PROD_W-1:0] qp [6];
  dvec_t                    b_e1, b_e2, b_s, b_dir;

  logic adv_a, adv_b, adv_c;

  assign adv_c    = !out_valid || out_ready;
  assign adv_b    = !b_valid || adv_c;
  assign adv_a    = !a_valid || adv_b;
  assign in_ready = adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) a_valid <= in_valid;
      if (adv_b) b_valid <= a_valid;
      if (adv_c) out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      a_e1  <= vdiff(in_facet.b, in_facet.a);
      a_e2  <= vdiff(in_facet.c, in_facet.a);
      a_s   <= vdiff(origin, in_facet.a);
      a_dir <= vdiff(seg_end, origin);
    end
    if (adv_b && a_valid) begin
      hp[0] <= mul_d(a_dir.y, a_e2.z);
      hp[1] <= mul_d(a_dir.z, a_e2.y);
      hp[2] <= mul_d(a_dir.z, a_e2.x);
      hp[3] <= mul_d(a_dir.x, a_e2.z);
      hp[4] <= mul_d(a_dir.x, a_e2.y);
      hp[5] <= mul_d(a_dir.y, a_e2.x);
      qp[0] <= mul_d(a_s.y, a_e1.z);
      qp[1] <= mul_d(a_s.z, a_e1.y);
      qp[2] <= mul_d(a_s.z, a_e1.x);
      qp[3] <= mul_d(a_s.x, a_e1.z);
      qp[4] <= mul_d(a_s.x, a_e1.y);
      qp[5] <= mul_d(a_s.y, a_e1.x);
      b_e1  <= a_e1;
      b_e2  <= a_e2;
      b_s   <= a_s;
      b_dir <= a_dir;
    end
    if (adv_c && b_valid) begin
      out_data.h.x <= CROSS_W'(hp[0]) - CROSS_W'(hp[1]);
      out_data.h.y <= CROSS_W'(hp[2]) - CROSS_W'(hp[3]);
      out_data.h.z <= CROSS_W'(hp[4]) - CROSS_W'(hp[5]);
      out_data.q.x <= CROSS_W'(qp[0]) - CROSS_W'(qp[1]);
      out_data.q.y <= CROSS_W'(qp[2]) - CROSS_W'(qp[3]);
      out_data.q.z <= CROSS_W'(qp[4]) - CROSS_W'(qp[5]);
      out_data.e1  <= b_e1;
      out_data.e2  <= b_e2;
      out_data.s   <= b_s;
      out_data.dir <= b_dir;
    end
  end

endmodule

// ===== design/sthit_dot.sv =====
// four dot products: split partial products, terms, sums
module sthit_dot (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sthit_pkg::cross_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sthit_pkg::dot_t   out_data
);
  import sthit_pkg::*;

  localparam int NPROD = 12;

  logic signed [DIFF_W-1:0]  opd [NPROD];
  logic signed [CROSS_W-1:0] opc [NPROD];

  logic                        a_valid;
  logic signed [PART_LO_W-1:0] plo [NPROD];
  logic signed [PART_HI_W-1:0] phi [NPROD];
  logic                        b_valid;
  logic signed [TERM_W-1:0]    term [NPROD];

  logic adv_a, adv_b, adv_c;

  // lanes 0..2 det, 3..5 nu, 6..8 nv, 9..11 nt
  always_comb begin
    opd[0]  = in_data.e1.x;  opc[0]  = in_data.h.x;
    opd[1]  = in_data.e1.y;  opc[1]  = in_data.h.y;
    opd[2]  = in_data.e1.z;  opc[2]  = in_data.h.z;
    opd[3]  = in_data.s.x;   opc[3]  = in_data.h.x;
    opd[4]  = in_data.s.y;   opc[4]  = in_data.h.y;
    opd[5]  = in_data.s.z;   opc[5]  = in_data.h.z;
    opd[6]  = in_data.dir.x; opc[6]  = in_data.q.x;
    opd[7]  = in_data.dir.y; opc[7]  = in_data.q.y;
    opd[8]  = in_data.dir.z; opc[8]  = in_data.q.z;
    opd[9]  = in_data.e2.x;  opc[9]  = in_data.q.x;
    opd[10] = in_data.e2.y;  opc[10] = in_data.q.y;
    opd[11] = in_data.e2.z;  opc[11] = in_data.q.z;
  end

  assign adv_c    = !out_valid || out_ready;
  assign adv_b    = !b_valid || adv_c;
  assign adv_a    = !a_valid || adv_b;
  assign in_ready = adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) a_valid <= in_valid;
      if (adv_b) b_valid <= a_valid;
      if (adv_c) out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      for (int i = 0; i < NPROD; i++) begin
        // low half as a non-negative operand, high half keeps the sign
        plo[i] <= PART_LO_W'(opd[i]) *
                  PART_LO_W'($signed({1'b0, opc[i][LO_W-1:0]}));
        phi[i] <= PART_HI_W'(opd[i]) * PART_HI_W'($signed(opc[i][CROSS_W-1:LO_W]));
      end
    end
    if (adv_b && a_valid) begin
      for (int i = 0; i < NPROD; i++) begin
        term[i] <= (TERM_W'(phi[i]) <<< LO_W) + TERM_W'(plo[i]);
      end
    end
    if (adv_c && b_valid) begin
      out_data.det <= DOT_W'(term[0]) + DOT_W'(term[1]) + DOT_W'(term[2]);
      out_data.nu  <= DOT_W'(term[3]) + DOT_W'(term[4]) + DOT_W'(term[5]);
      out_data.nv  <= DOT_W'(term[6]) + DOT_W'(term[7]) + DOT_W'(term[8]);
      out_data.nt  <= DOT_W'(term[9]) + DOT_W'(term[10]) + DOT_W'(term[11]);
    end
  end

endmodule

// ===== design/sthit_decide.sv =====
// sign folding and the bound compares that give hit and reason
module sthit_decide (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sthit_pkg::dot_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output sthit_pkg::reason_t out_reason
);
  import sthit_pkg::*;

  logic                     a_valid;
  logic signed [FOLD_W-1:0] f_det, f_nu, f_nv, f_nt;
  logic                     neg;

  logic signed [SUM_W-1:0] uv_sum;
  logic                    det_zero, u_bad, v_bad, t_good;
  reason_t                 reason_next;

  logic adv_a, adv_b;

  assign adv_b    = !out_valid || out_ready;
  assign adv_a    = !a_valid || adv_b;
  assign in_ready = adv_a;

  assign neg = in_data.det[DOT_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) a_valid <= in_valid;
      if (adv_b) out_valid <= a_valid;
    end
  end

  // make det non-negative, flip the numerators with it
  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      f_det <= neg ? -FOLD_W'(in_data.det) : FOLD_W'(in_data.det);
      f_nu  <= neg ? -FOLD_W'(in_data.nu)  : FOLD_W'(in_data.nu);
      f_nv  <= neg ? -FOLD_W'(in_data.nv)  : FOLD_W'(in_data.nv);
      f_nt  <= neg ? -FOLD_W'(in_data.nt)  : FOLD_W'(in_data.nt);
    end
  end

  always_comb begin
    uv_sum   = SUM_W'(f_nu) + SUM_W'(f_nv);
    det_zero = (f_det == '0);
    u_bad    = f_nu[FOLD_W-1] || (f_nu > f_det);
    v_bad    = f_nv[FOLD_W-1] || (uv_sum > SUM_W'(f_det));
    t_good   = !f_nt[FOLD_W-1] && (f_nt != '0) && (f_nt < f_det);
    if (det_zero) begin
      reason_next = REASON_PARALLEL;
    end else if (u_bad) begin
      reason_next = REASON_U_OUT;
    end else if (v_bad) begin
      reason_next = REASON_V_OUT;
    end else if (t_good) begin
      reason_next = REASON_HIT;
    end else begin
      reason_next = REASON_T_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b && a_valid) begin
      out_reason <= reason_next;
      out_hit    <= (reason_next == REASON_HIT);
    end
  end

endmodule

// ===== design/segment_triangle_hit_test.sv =====
// top level of the segment / triangle hit test
// One segment (origin and end point, signed Q16.16) sits in six write-only
// registers, and triangles stream past it one word per cycle while no stall
// holds the pipe. Each triangle gives one result word: a hit flag and a
// reason code (hit, parallel, u outside, v outside, t outside), checked in
// that order with the first failure winning. The arithmetic is exact
// Moller-Trumbore with no division; a zero determinant counts as parallel,
// edges of the triangle count as inside and t must lie strictly between the
// two segment ends. The datapath is eight register stages (edge vectors,
// cross products split into products and differences, dot products split
// into partial products, terms and sums, sign folding, and the compare stage
// that doubles as the output register). Ready is high whenever the result
// side is ready or a bubble sits anywhere in the pipe; a stall holds each
// stage with no bubble beyond it in place. Registers are to be written only
// while no triangle is in flight.
module segment_triangle_hit_test (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sthit_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  sthit_pkg::coord_t                cfg_data,
  sthit_facet_if.sink                      facet,
  sthit_result_if.source                   result
);
  import sthit_pkg::*;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_END_X    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_END_Y    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_END_Z    = CFG_IDX_W'(5);

  point_t seg_origin;
  point_t seg_end;
  facet_t in_facet;

  // stage handoff between the units
  logic   cross_valid, cross_ready;
  cross_t cross_data;
  logic   dot_valid, dot_ready;
  dot_t   dot_data;

  // segment registers, writes past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_origin <= '0;
      seg_end    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ORIGIN_X: seg_origin.x <= cfg_data;
        REG_ORIGIN_Y: seg_origin.y <= cfg_data;
        REG_ORIGIN_Z: seg_origin.z <= cfg_data;
        REG_END_X:    seg_end.x    <= cfg_data;
        REG_END_Y:    seg_end.y    <= cfg_data;
        REG_END_Z:    seg_end.z    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // gather the incoming word into vertex form
  assign in_facet.a.x = facet.vert_a_x;
  assign in_facet.a.y = facet.vert_a_y;
  assign in_facet.a.z = facet.vert_a_z;
  assign in_facet.b.x = facet.vert_b_x;
  assign in_facet.b.y = facet.vert_b_y;
  assign in_facet.b.z = facet.vert_b_z;
  assign in_facet.c.x = facet.vert_c_x;
  assign in_facet.c.y = facet.vert_c_y;
  assign in_facet.c.z = facet.vert_c_z;

  // edges, dir and the cross products h = dir x e2, q = s x e1
  sthit_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (facet.valid),
    .in_ready  (facet.ready),
    .in_facet  (in_facet),
    .origin    (seg_origin),
    .seg_end   (seg_end),
    .out_valid (cross_valid),
    .out_ready (cross_ready),
    .out_data  (cross_data)
  );

  // det = e1.h, nu = s.h, nv = dir.q, nt = e2.q
  sthit_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .in_ready  (cross_ready),
    .in_data   (cross_data),
    .out_valid (dot_valid),
    .out_ready (dot_ready),
    .out_data  (dot_data)
  );

  // sign fold against det, then the bound tests; last stage is the output
  sthit_decide u_decide (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dot_valid),
    .in_ready   (dot_ready),
    .in_data    (dot_data),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_hit    (result.hit),
    .out_reason (result.reason)
  );

endmodule

// ===== design/sthit_checker.sv =====
// port-level checks for the hit test, bound to the top level
module sthit_checker (
  input logic            clk,
  input logic            rst,
  sthit_facet_if.sink    facet,
  sthit_result_if.source result
);
  import sthit_pkg::*;

  logic accept, degenerate;

  assign accept     = facet.valid && facet.ready;
  assign degenerate = (facet.vert_b_x == facet.vert_a_x) &&
                      (facet.vert_b_y == facet.vert_a_y) &&
                      (facet.vert_b_z == facet.vert_a_z) &&
                      (facet.vert_c_x == facet.vert_a_x) &&
                      (facet.vert_c_y == facet.vert_a_y) &&
                      (facet.vert_c_z == facet.vert_a_z);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  // an open output lets every stage move, so input must be ready
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    result.ready |-> facet.ready)
    else $error("input stalled while output ready");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=>
      result.valid && $stable(result.hit) && $stable(result.reason))
    else $error("result word changed while stalled");

  // collapsed triangle comes out as parallel when the output stays ready throughout
  a_degenerate: assert property (@(posedge clk) disable iff (rst)
    (accept && degenerate && result.ready) ##1 result.ready ##1 result.ready
      ##1 result.ready ##1 result.ready ##1 result.ready ##1 result.ready
      ##1 result.ready
    |=> result.valid && !result.hit && (result.reason == REASON_PARALLEL))
    else $error("degenerate triangle not reported as parallel");

endmodule

bind segment_triangle_hit_test sthit_checker u_sthit_checker (
  .clk    (clk),
  .rst    (rst),
  .facet  (facet),
  .result (result)
);
